/* src/itrt_pkg.sv */
// ----------------------------------------------------------------------------
// itrt_pkg
// shared constants, types and helpers of the integer to radix text block
// ----------------------------------------------------------------------------
package itrt_pkg;

  // alphabet storage: sixteen byte symbols in two 64-bit registers
  localparam int SymCount   = 16;
  localparam int SymIdxW    = 4;
  localparam int AlphaW     = SymCount * 8;
  localparam int MaxSymbols = 16;
  localparam int MinRadix   = 2;

  // magnitude, digit and count widths
  localparam int MagWidth  = 32;
  localparam int MaxDigits = 32;
  localparam int DigitW    = 4;
  localparam int RadixW    = 5;
  localparam int CountW    = 6;

  // configuration
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 4;
  localparam logic RegAlphaLo = 1'b0;
  localparam logic RegAlphaHi = 1'b1;

  // character codes
  localparam logic [7:0] CharEnd   = 8'h00;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCtlLo = 8'h09;
  localparam logic [7:0] CharCtlHi = 8'h0D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } itrt_state_e;

  typedef struct packed {
    logic              done;
    logic              ok;
    logic [RadixW-1:0] radix;
  } chk_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic one_left;
  } stk_stat_t;

  function automatic logic [7:0] sym_at(input logic [AlphaW-1:0] alpha,
                                        input logic [SymIdxW-1:0] k);
    return alpha[{k, 3'b000} +: 8];
  endfunction

endpackage

/* src/integer_to_radix_text_top.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// signed 32-bit integer to text in a radix set by a configured alphabet
// ----------------------------------------------------------------------------
// usage
//   - apb port: 64-bit alphabet_low_symbols at 0x0, alphabet_high_symbols at
//     0x8; write them only while busy is low; reset clears both to zero
//   - command: pulse start with number_i while busy is low; busy rises the
//     next cycle and stays high until the last character is out
//   - results: one character per cycle on character_o with char_valid_o,
//     '-' first for a negative number, then digits most significant first;
//     last_char_o marks the final character; an invalid alphabet makes the
//     number produce no transfer at all
//   - sequence: the alphabet scan runs first, then each digit comes from the
//     bit-serial divider (one quotient bit per cycle over 32 bits), then the
//     sign, if any, and the digits most significant first are output
//   - the receiver cannot stall: each result is shown for one cycle only
//   - reset clears control state and returns the block to idle
// ----------------------------------------------------------------------------
module integer_to_radix_text_top #(
  parameter int MaxSymbols = itrt_pkg::MaxSymbols
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic signed [itrt_pkg::MagWidth-1:0] number_i,
  // result channel
  output logic                          char_valid_o,
  output logic [7:0]                    character_o,
  output logic                          last_char_o,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itrt_pkg::CfgAddrW-1:0] paddr,
  input  logic [itrt_pkg::CfgDataW-1:0] pwdata,
  output logic [itrt_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import itrt_pkg::*;

  // configuration registers
  logic [CfgDataW-1:0] alpha_lo_q;
  logic [CfgDataW-1:0] alpha_hi_q;
  logic [AlphaW-1:0]   alpha;
  logic                cfg_wr;

  // control and item state
  itrt_state_e         state_q, state_d;
  logic                neg_q, neg_d;
  logic [MagWidth-1:0] mag_q, mag_d;

  // output registers
  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;

  // unit interfaces
  logic                chk_start;
  chk_stat_t           chk_stat;
  logic                div_start;
  logic [MagWidth-1:0] div_value;
  logic                div_done;
  logic [MagWidth-1:0] div_quot;
  logic [DigitW-1:0]   div_rem;
  stk_cmd_t            stk_cmd;
  logic [DigitW-1:0]   stk_top;
  stk_stat_t           stk_stat;

  // --------------------------------------------------------------------------
  // apb: write completes in the access phase, no wait states
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == RegAlphaHi) ? alpha_hi_q : alpha_lo_q;
  assign alpha  = {alpha_hi_q, alpha_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == RegAlphaHi) begin
        alpha_hi_q <= pwdata;
      end else begin
        alpha_lo_q <= pwdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // processing units
  // --------------------------------------------------------------------------
  itrt_alpha_check #(
    .MaxSymbols (MaxSymbols)
  ) u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (chk_start),
    .alpha_i (alpha),
    .stat_o  (chk_stat)
  );

  itrt_div_serial u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (div_value),
    .radix_i (chk_stat.radix),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  itrt_digit_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stk_cmd),
    .digit_i (div_rem),
    .top_o   (stk_top),
    .stat_o  (stk_stat)
  );

  // --------------------------------------------------------------------------
  // sequencer: check alphabet, divide out digits, emit sign, pop digits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    chk_start = 1'b0;
    div_start = 1'b0;
    div_value = mag_q;
    stk_cmd   = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          neg_d     = number_i[MagWidth-1];
          // two's complement negate; the most negative value maps to 2^31
          mag_d     = number_i[MagWidth-1] ? unsigned'(-number_i) : unsigned'(number_i);
          chk_start = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_stat.done) begin
          if (chk_stat.ok) begin
            div_start = 1'b1;
            state_d   = ST_DIVIDE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIVIDE: begin
        div_value = div_quot;
        if (div_done) begin
          stk_cmd.push = 1'b1;
          if (div_quot != '0) begin
            div_start = 1'b1;
          end else begin
            state_d = neg_q ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        valid_d = 1'b1;
        char_d  = CharMinus;
        last_d  = 1'b0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        stk_cmd.pop = 1'b1;
        valid_d     = 1'b1;
        char_d      = sym_at(alpha, stk_top);
        last_d      = stk_stat.one_left;
        if (stk_stat.one_left) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy         = (state_q != ST_IDLE);
  assign char_valid_o = valid_q;
  assign character_o  = char_q;
  assign last_char_o  = last_q;

`ifndef SYNTHESIS
  // an accepted command always moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // the final character is never followed directly by another one
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && last_char_o |=> !char_valid_o)
    else $error("transfer right after last character");

  // every digit pushed for an item is popped before returning to idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> stk_stat.empty)
    else $error("digit stack not empty in idle");

  // output phase always has at least one digit to pop
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !stk_stat.empty)
    else $error("emit with empty digit stack");
`endif

endmodule

/* src/itrt_alpha_check.sv */
// ----------------------------------------------------------------------------
// itrt_alpha_check
// serial alphabet scan: one symbol per cycle, finds radix and validity
// ----------------------------------------------------------------------------
module itrt_alpha_check #(
  parameter int MaxSymbols = itrt_pkg::MaxSymbols
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [itrt_pkg::AlphaW-1:0] alpha_i,
  output itrt_pkg::chk_stat_t       stat_o
);
  import itrt_pkg::*;

  logic              run_q;
  logic [RadixW-1:0] idx_q;
  logic              bad_q;
  chk_stat_t         stat_q;

  logic [7:0] cur;
  logic       stop;
  logic       bad_now;

  always_comb begin
    cur     = sym_at(alpha_i, idx_q[SymIdxW-1:0]);
    stop    = (idx_q == RadixW'(MaxSymbols)) || (cur == CharEnd);
    bad_now = cur inside {CharPlus, CharMinus, CharSpace, [CharCtlLo:CharCtlHi]};
    // compare against every earlier symbol
    for (int j = 0; j < SymCount; j++) begin
      if ((RadixW'(j) < idx_q) && (sym_at(alpha_i, SymIdxW'(j)) == cur)) begin
        bad_now = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      idx_q  <= '0;
      bad_q  <= 1'b0;
      stat_q <= '0;
    end else begin
      stat_q.done <= run_q && !start_i && stop;
      if (start_i) begin
        run_q <= 1'b1;
        idx_q <= '0;
        bad_q <= 1'b0;
      end else if (run_q) begin
        if (stop) begin
          run_q        <= 1'b0;
          stat_q.ok    <= !bad_q && (idx_q >= RadixW'(MinRadix));
          stat_q.radix <= idx_q;
        end else begin
          idx_q <= idx_q + 1'b1;
          bad_q <= bad_q | bad_now;
        end
      end
    end
  end

  assign stat_o = stat_q;

endmodule

/* src/itrt_div_serial.sv */
// ----------------------------------------------------------------------------
// itrt_div_serial
// bit-serial restoring divider: dividend shifts through, quotient shifts in
// ----------------------------------------------------------------------------
module itrt_div_serial (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [itrt_pkg::MagWidth-1:0] value_i,
  input  logic [itrt_pkg::RadixW-1:0]   radix_i,
  output logic                        done_o,
  output logic [itrt_pkg::MagWidth-1:0] quot_o,
  output logic [itrt_pkg::DigitW-1:0]   rem_o
);
  import itrt_pkg::*;

  localparam int CntW = $clog2(MagWidth);
  localparam logic [CntW-1:0] LastStep = CntW'(MagWidth - 1);

  logic                run_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [MagWidth-1:0] dvd_q;
  logic [DigitW-1:0]   rem_q;

  logic [DigitW:0]   trial;
  logic              ge;
  logic [DigitW-1:0] rem_d;

  // partial remainder stays below the radix, so one trial subtract per bit
  always_comb begin
    trial = {rem_q, dvd_q[MagWidth-1]};
    ge    = (trial >= radix_i);
    rem_d = ge ? DigitW'(trial - radix_i) : trial[DigitW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && !start_i && (cnt_q == LastStep);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= value_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[MagWidth-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

/* src/itrt_digit_stack.sv */
// ----------------------------------------------------------------------------
// itrt_digit_stack
// digit lifo built as a shift register, newest digit in the low nibble
// ----------------------------------------------------------------------------
module itrt_digit_stack (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  itrt_pkg::stk_cmd_t        cmd_i,
  input  logic [itrt_pkg::DigitW-1:0] digit_i,
  output logic [itrt_pkg::DigitW-1:0] top_o,
  output itrt_pkg::stk_stat_t       stat_o
);
  import itrt_pkg::*;

  localparam int StackW = MaxDigits * DigitW;

  logic [StackW-1:0] data_q;
  logic [CountW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.push) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      data_q <= {data_q[StackW-DigitW-1:0], digit_i};
    end else if (cmd_i.pop) begin
      data_q <= {DigitW'(0), data_q[StackW-1:DigitW]};
    end
  end

  assign top_o           = data_q[DigitW-1:0];
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.one_left = (cnt_q == CountW'(1));

endmodule
